// ===== rtl/lrfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_pkg
// Shared types and constants of the line raster frame store.
// ----------------------------------------------------------------------------
package lrfs_pkg;

    localparam int WIDTH_MAX_DEF  = 256;
    localparam int HEIGHT_MAX_DEF = 256;

    localparam int CRD_W      = 16;
    localparam int POS_W      = CRD_W + 1;
    localparam int DLT_W      = POS_W;
    localparam int ERR_W      = 19;
    localparam int YPOS_W     = 19;
    localparam int SCR_W      = 9;
    localparam int DIM_W      = 13;
    localparam int RD_W       = 8;
    localparam int ADDR_EXT_W = SCR_W + DIM_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int COLOR_W    = 24;
    localparam int IN_DATA_W  = 4 * CRD_W + 2 * RD_W;
    localparam int OUT_USER_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
    localparam logic [SCR_W-1:0]   SCR_RST     = 9'd256;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN      = 2'd0,
        REG_Y_ORIGIN      = 2'd1,
        REG_SCREEN_WIDTH  = 2'd2,
        REG_SCREEN_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_LINE,
        CMD_VLINE,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        logic [SCR_W-1:0] w;
        logic [SCR_W-1:0] h;
    } t_screen;

    typedef struct packed {
        t_cmd_kind                kind;
        logic                     rd_outside;
        logic [RD_W-1:0]          rd_x;
        logic [RD_W-1:0]          rd_y;
        logic signed [POS_W-1:0]  x0;
        logic signed [POS_W-1:0]  y0;
        logic signed [POS_W-1:0]  x1;
        logic [DLT_W-1:0]         adx;
        logic [DLT_W-1:0]         ady;
        logic                     sx_neg;
        logic                     sy_neg;
        logic [SCR_W-1:0]         v_lo;
        logic [SCR_W-1:0]         v_hi;
    } t_cmd;

endpackage

// ===== rtl/line_raster_frame_store.sv =====
`timescale 1ns / 1ps
// A read passes the front register and the queue, reads the frame store as it
// leaves the queue and gets its result registered in ST_RESULT. A sloped line
// visits ST_LINE_X and ST_LINE_Y per column, ST_LINE_Y again per extra row step.
// The frame store takes one pixel write a cycle; the clear and ST_VLINE run that fast.
// Reset: after i_rst_n is released a clearing pass writes white to all
// WIDTH_MAX*HEIGHT_MAX pixels with s_axis_tready low.
// ----------------------------------------------------------------------------
// line_raster_frame_store
// Line drawing engine over a one-bit frame store with pixel read back.
// ----------------------------------------------------------------------------
module line_raster_frame_store
    import lrfs_pkg::*;
#(
    parameter int WIDTH_MAX  = WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // from_x, from_y, to_x, to_y, read_x, read_y
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pixel_color
    output logic [COLOR_W-1:0]      m_axis_tdata,
    // line_done, read_outside
    output logic [OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic    w_busy;
    logic    w_q_full;
    logic    w_q_empty;
    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_screen w_screen;
    logic    w_done;
    logic    w_outside;

    assign m_axis_tuser = {w_outside, w_done};

    lrfs_front #(
        .WIDTH_MAX  (WIDTH_MAX),
        .HEIGHT_MAX (HEIGHT_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_from_x    (s_axis_tdata[15:0]),
        .i_from_y    (s_axis_tdata[31:16]),
        .i_to_x      (s_axis_tdata[47:32]),
        .i_to_y      (s_axis_tdata[63:48]),
        .i_read_x    (s_axis_tdata[71:64]),
        .i_read_y    (s_axis_tdata[79:72]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_busy      (w_busy),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .o_screen    (w_screen)
    );

    lrfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_q_empty)
    );

    lrfs_back #(
        .WIDTH_MAX  (WIDTH_MAX),
        .HEIGHT_MAX (HEIGHT_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_q_empty),
        .i_cmd     (w_cmd_out),
        .o_pop     (w_pop),
        .i_screen  (w_screen),
        .o_busy    (w_busy),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_color   (m_axis_tdata),
        .o_done    (w_done),
        .o_outside (w_outside)
    );

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> w_busy)
        else $error("clearing pass did not start after reset");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !w_busy)
        else $error("result presented during clearing pass");

    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_done || w_outside) |-> !(w_done && w_outside)
            && (m_axis_tdata == COLOR_BLACK))
        else $error("inconsistent result fields");

    a_pop_only_when_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty && !w_busy)
        else $error("command taken from empty queue or during clearing");

endmodule

// ===== rtl/lrfs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_front
// Holds the configuration registers, offsets accepted commands by the origin
// and classifies them into queue entries for the drawing engine.
// ----------------------------------------------------------------------------
module lrfs_front
    import lrfs_pkg::*;
#(
    parameter int WIDTH_MAX  = WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_op,
    input  logic signed [CRD_W-1:0]  i_from_x,
    input  logic signed [CRD_W-1:0]  i_from_y,
    input  logic signed [CRD_W-1:0]  i_to_x,
    input  logic signed [CRD_W-1:0]  i_to_y,
    input  logic [RD_W-1:0]          i_read_x,
    input  logic [RD_W-1:0]          i_read_y,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_busy,
    input  logic                     i_q_full,
    output logic                     o_push,
    output t_cmd                     o_cmd,
    output t_screen                  o_screen
);

    function automatic logic [SCR_W-1:0] sat_dim(input logic [SCR_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        return (DIM_W'(v) > lim) ? lim[SCR_W-1:0] : v;
    endfunction

    logic signed [CRD_W-1:0] r_x_org;
    logic signed [CRD_W-1:0] r_y_org;
    t_screen                 r_scr;

    logic                    r_valid;
    logic                    r_op;
    logic signed [POS_W-1:0] r_fx;
    logic signed [POS_W-1:0] r_fy;
    logic signed [POS_W-1:0] r_tx;
    logic signed [POS_W-1:0] r_ty;
    logic [RD_W-1:0]         r_rx;
    logic [RD_W-1:0]         r_ry;

    logic                    accept;
    logic                    sx_neg;
    logic                    sy_neg;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] lo_c;
    logic signed [POS_W-1:0] hi_c;
    logic signed [POS_W-1:0] w_s;
    logic signed [POS_W-1:0] h_s;
    logic                    x_on;
    logic                    v_empty;

    assign o_cfg_ready = 1'b1;
    assign o_screen    = r_scr;
    assign o_push      = r_valid && !i_q_full;
    assign o_ready     = !i_busy && (!r_valid || !i_q_full);
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_org <= '0;
            r_y_org <= '0;
            r_scr.w <= sat_dim(SCR_RST, DIM_W'(WIDTH_MAX));
            r_scr.h <= sat_dim(SCR_RST, DIM_W'(HEIGHT_MAX));
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_X_ORIGIN:      r_x_org <= i_cfg_data;
                REG_Y_ORIGIN:      r_y_org <= i_cfg_data;
                REG_SCREEN_WIDTH:  r_scr.w <= sat_dim(i_cfg_data[SCR_W-1:0],
                                                      DIM_W'(WIDTH_MAX));
                REG_SCREEN_HEIGHT: r_scr.h <= sat_dim(i_cfg_data[SCR_W-1:0],
                                                      DIM_W'(HEIGHT_MAX));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_op <= i_op;
            r_fx <= POS_W'(i_from_x) + POS_W'(r_x_org);
            r_fy <= POS_W'(i_from_y) + POS_W'(r_y_org);
            r_tx <= POS_W'(i_to_x) + POS_W'(r_x_org);
            r_ty <= POS_W'(i_to_y) + POS_W'(r_y_org);
            r_rx <= i_read_x;
            r_ry <= i_read_y;
        end
    end

    always_comb begin
        w_s     = POS_W'(r_scr.w);
        h_s     = POS_W'(r_scr.h);
        sx_neg  = r_fx > r_tx;
        sy_neg  = r_fy > r_ty;
        lo      = sy_neg ? r_ty : r_fy;
        hi      = sy_neg ? r_fy : r_ty;
        lo_c    = (lo < 0) ? '0 : lo;
        hi_c    = (hi > h_s) ? h_s : hi;
        x_on    = !r_fx[POS_W-1] && (r_fx < w_s);
        v_empty = !x_on || (lo_c >= hi_c);

        o_cmd.rd_outside = (SCR_W'(r_rx) >= r_scr.w) || (SCR_W'(r_ry) >= r_scr.h);
        o_cmd.rd_x       = r_rx;
        o_cmd.rd_y       = r_ry;
        o_cmd.x0         = r_fx;
        o_cmd.y0         = r_fy;
        o_cmd.x1         = r_tx;
        o_cmd.adx        = sx_neg ? DLT_W'(r_fx - r_tx) : DLT_W'(r_tx - r_fx);
        o_cmd.ady        = sy_neg ? DLT_W'(r_fy - r_ty) : DLT_W'(r_ty - r_fy);
        o_cmd.sx_neg     = sx_neg;
        o_cmd.sy_neg     = sy_neg;
        o_cmd.v_lo       = lo_c[SCR_W-1:0];
        o_cmd.v_hi       = hi_c[SCR_W-1:0];

        if (r_op == OP_READ) begin
            o_cmd.kind = CMD_READ;
        end else if (r_fx != r_tx) begin
            o_cmd.kind = CMD_LINE;
        end else if (v_empty) begin
            o_cmd.kind = CMD_NOP;
        end else begin
            o_cmd.kind = CMD_VLINE;
        end
    end

endmodule

// ===== rtl/lrfs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_queue
// Short command queue between the classifier and the drawing engine.
// ----------------------------------------------------------------------------
module lrfs_queue
    import lrfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/lrfs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfs_back
// Drawing engine: clears the frame store after reset, walks one line at a time
// pixel by pixel, serves pixel reads and registers the results.
// ----------------------------------------------------------------------------
module lrfs_back
    import lrfs_pkg::*;
#(
    parameter int WIDTH_MAX  = WIDTH_MAX_DEF,
    parameter int HEIGHT_MAX = HEIGHT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  t_screen            i_screen,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_done,
    output logic               o_outside
);

    localparam int DEPTH = WIDTH_MAX * HEIGHT_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE_X,
        ST_LINE_Y,
        ST_VLINE,
        ST_RESULT
    } t_state;

    function automatic logic [AW-1:0] pix_addr(input logic [SCR_W-1:0] px,
                                               input logic [SCR_W-1:0] py);
        logic [ADDR_EXT_W-1:0] a;
        a = ADDR_EXT_W'(py) * ADDR_EXT_W'(WIDTH_MAX) + ADDR_EXT_W'(px);
        return AW'(a);
    endfunction

    logic                     r_frame [DEPTH];
    logic                     r_rd_data;

    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_is_read;
    logic                     r_outside;
    logic signed [POS_W-1:0]  r_x;
    logic signed [POS_W-1:0]  r_x1;
    logic signed [YPOS_W-1:0] r_y;
    logic signed [ERR_W-1:0]  r_err;
    logic [DLT_W-1:0]         r_adx;
    logic [DLT_W-1:0]         r_ady;
    logic [DLT_W-2:0]         r_half;
    logic                     r_sx_neg;
    logic                     r_sy_neg;
    logic [SCR_W-1:0]         r_vy;
    logic [SCR_W-1:0]         r_vhi;

    logic                     r_out_valid;
    logic [COLOR_W-1:0]       r_out_color;
    logic                     r_out_done;
    logic                     r_out_outside;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     on_screen;
    logic                     err_high;
    logic                     out_free;
    logic signed [POS_W-1:0]  x_nx;

    assign o_busy    = r_state == ST_CLEAR;
    assign o_valid   = r_out_valid;
    assign o_color   = r_out_color;
    assign o_done    = r_out_done;
    assign o_outside = r_out_outside;
    assign out_free  = !r_out_valid || i_ready;

    always_comb begin
        on_screen = !r_x[POS_W-1] && (r_x < $signed(POS_W'(i_screen.w)))
                 && !r_y[YPOS_W-1] && (r_y < $signed(YPOS_W'(i_screen.h)));
        err_high  = r_err > $signed(ERR_W'(r_half));
        x_nx      = r_sx_neg ? r_x - POS_W'(1) : r_x + POS_W'(1);
        o_pop     = (r_state == ST_IDLE) && !i_empty;
        rd_en     = o_pop && (i_cmd.kind == CMD_READ) && !i_cmd.rd_outside;
        rd_addr   = pix_addr(SCR_W'(i_cmd.rd_x), SCR_W'(i_cmd.rd_y));
        wr_en     = 1'b0;
        wr_data   = 1'b0;
        wr_addr   = pix_addr(r_x[SCR_W-1:0], r_y[SCR_W-1:0]);
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = 1'b1;
                wr_addr = r_clr_addr;
            end
            ST_LINE_X: begin
                wr_en = on_screen;
            end
            ST_LINE_Y: begin
                wr_en = on_screen && err_high;
            end
            ST_VLINE: begin
                wr_en   = 1'b1;
                wr_addr = pix_addr(r_x[SCR_W-1:0], r_vy);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_frame[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != ST_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_pop) begin
                        r_is_read <= i_cmd.kind == CMD_READ;
                        r_outside <= i_cmd.rd_outside;
                        r_x       <= i_cmd.x0;
                        r_x1      <= i_cmd.x1;
                        r_y       <= YPOS_W'(i_cmd.y0);
                        r_err     <= '0;
                        r_adx     <= i_cmd.adx;
                        r_ady     <= i_cmd.ady;
                        r_half    <= i_cmd.adx[DLT_W-1:1];
                        r_sx_neg  <= i_cmd.sx_neg;
                        r_sy_neg  <= i_cmd.sy_neg;
                        r_vy      <= i_cmd.v_lo;
                        r_vhi     <= i_cmd.v_hi;
                        case (i_cmd.kind)
                            CMD_LINE:  r_state <= ST_LINE_X;
                            CMD_VLINE: r_state <= ST_VLINE;
                            default:   r_state <= ST_RESULT;
                        endcase
                    end
                end
                ST_LINE_X: begin
                    r_err   <= r_err + $signed(ERR_W'(r_ady));
                    r_state <= ST_LINE_Y;
                end
                ST_LINE_Y: begin
                    if (err_high) begin
                        r_y   <= r_sy_neg ? r_y - YPOS_W'(1) : r_y + YPOS_W'(1);
                        r_err <= r_err - $signed(ERR_W'(r_adx));
                    end else if (x_nx == r_x1) begin
                        r_state <= ST_RESULT;
                    end else begin
                        r_x     <= x_nx;
                        r_state <= ST_LINE_X;
                    end
                end
                ST_VLINE: begin
                    r_vy <= r_vy + 1'b1;
                    if (r_vy + 1'b1 == r_vhi) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                        if (r_is_read) begin
                            r_out_color   <= (!r_outside && r_rd_data) ? COLOR_WHITE
                                                                       : COLOR_BLACK;
                            r_out_done    <= 1'b0;
                            r_out_outside <= r_outside;
                        end else begin
                            r_out_color   <= COLOR_BLACK;
                            r_out_done    <= 1'b1;
                            r_out_outside <= 1'b0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== test/tb_line_raster_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_raster_frame_store
// Self-checking bench for the line raster frame store. Draw and read requests
// are streamed in with random gaps on both sides. A model of the frame store
// in the bench rasterizes every accepted line and predicts each read. Each
// response is then compared field by field in arrival order. The screen size
// and origin are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_line_raster_frame_store;
    import lrfs_pkg::*;

    localparam int PIX_W          = WIDTH_MAX_DEF;
    localparam int PIX_H          = HEIGHT_MAX_DEF;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int MAX_REPORTS    = 100;

    typedef struct {
        logic                    op;
        logic signed [CRD_W-1:0] fx;
        logic signed [CRD_W-1:0] fy;
        logic signed [CRD_W-1:0] tx;
        logic signed [CRD_W-1:0] ty;
        logic [RD_W-1:0]         rx;
        logic [RD_W-1:0]         ry;
    } t_raster_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               done;
        logic               outside;
    } t_pixel_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_DRAW;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]    m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = REG_X_ORIGIN;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    bit            pix_white [PIX_W*PIX_H];
    int            org_x;
    int            org_y;
    int            scr_w;
    int            scr_h;

    t_raster_cmd   cmd_backlog [$];
    t_pixel_result awaited_results [$];
    t_raster_cmd   held_cmd;

    int issued;
    int results_seen;
    int errors;
    int n_draws;
    int n_reads;
    int n_outside;
    int n_settings;
    int src_gap;
    int src_calm;
    int sink_wait;
    int sink_calm;
    int idle_cycles;

    line_raster_frame_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int visible_w();
        return (scr_w > PIX_W) ? PIX_W : scr_w;
    endfunction

    function automatic int visible_h();
        return (scr_h > PIX_H) ? PIX_H : scr_h;
    endfunction

    function automatic void blacken(int x, int y, int w, int h);
        if (x >= 0 && x < w && y >= 0 && y < h) begin
            pix_white[y*PIX_W + x] = 1'b0;
        end
    endfunction

    function automatic void raster_line(int fx, int fy, int tx, int ty);
        int w;
        int h;
        int lo;
        int hi;
        int adx;
        int ady;
        int err;
        int x;
        int y;
        int sx;
        int sy;
        w = visible_w();
        h = visible_h();
        if (tx == fx) begin
            lo = (fy < ty) ? fy : ty;
            hi = (fy < ty) ? ty : fy;
            if (fx < 0 || fx >= w) begin
                return;
            end
            if (lo < 0) lo = 0;
            if (hi > h) hi = h;
            for (y = lo; y < hi; y++) begin
                blacken(fx, y, w, h);
            end
            return;
        end
        adx = (tx > fx) ? tx - fx : fx - tx;
        ady = (ty > fy) ? ty - fy : fy - ty;
        sx  = (fx > tx) ? -1 : 1;
        sy  = (fy > ty) ? -1 : 1;
        err = 0;
        y   = fy;
        for (x = fx; x != tx; x += sx) begin
            blacken(x, y, w, h);
            err += ady;
            while (err > adx / 2) begin
                blacken(x, y, w, h);
                y   += sy;
                err -= adx;
            end
        end
    endfunction

    function automatic t_pixel_result raster_predict(t_raster_cmd c);
        t_pixel_result r;
        if (c.op == OP_DRAW) begin
            raster_line(int'(c.fx) + org_x, int'(c.fy) + org_y,
                        int'(c.tx) + org_x, int'(c.ty) + org_y);
            r = '{COLOR_BLACK, 1'b1, 1'b0};
        end else if (int'(c.rx) >= visible_w() || int'(c.ry) >= visible_h()) begin
            r = '{COLOR_BLACK, 1'b0, 1'b1};
        end else begin
            r = '{pix_white[int'(c.ry)*PIX_W + int'(c.rx)] ? COLOR_WHITE : COLOR_BLACK,
                  1'b0, 1'b0};
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    function automatic logic signed [CRD_W-1:0] to_field(int target, int origin);
        int v;
        v = target - origin;
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
        return v[CRD_W-1:0];
    endfunction

    function automatic t_raster_cmd line_cmd(int fx, int fy, int tx, int ty);
        t_raster_cmd c;
        c.op = OP_DRAW;
        c.fx = fx[CRD_W-1:0];
        c.fy = fy[CRD_W-1:0];
        c.tx = tx[CRD_W-1:0];
        c.ty = ty[CRD_W-1:0];
        c.rx = RD_W'($urandom);
        c.ry = RD_W'($urandom);
        return c;
    endfunction

    function automatic t_raster_cmd read_cmd(int rx, int ry);
        t_raster_cmd c;
        c.op = OP_READ;
        c.fx = CRD_W'($urandom);
        c.fy = CRD_W'($urandom);
        c.tx = CRD_W'($urandom);
        c.ty = CRD_W'($urandom);
        c.rx = rx[RD_W-1:0];
        c.ry = ry[RD_W-1:0];
        return c;
    endfunction

    // The screen is drawn mostly with short lines around the visible area; the
    // field values are shifted by the origin so that the high bits also toggle.
    function automatic t_raster_cmd random_line();
        t_raster_cmd c;
        int fx;
        int fy;
        int tx;
        int ty;
        int span;
        int kind;
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 9) == 0) ? 300 : 40;
        fx   = int'($urandom_range(0, 300)) - 20;
        fy   = int'($urandom_range(0, 300)) - 20;
        tx   = fx + int'($urandom_range(0, 2*span)) - span;
        ty   = fy + int'($urandom_range(0, 2*span)) - span;
        if (kind < 15) begin
            tx = fx;
        end else if (kind < 22) begin
            tx = fx;
            ty = fy;
        end else if (kind < 32) begin
            ty = fy;
        end else if (kind < 45) begin
            tx = fx + int'($urandom_range(0, 6)) - 3;
        end
        c    = line_cmd(0, 0, 0, 0);
        c.fx = to_field(fx, org_x);
        c.fy = to_field(fy, org_y);
        c.tx = to_field(tx, org_x);
        c.ty = to_field(ty, org_y);
        return c;
    endfunction

    function automatic t_raster_cmd random_read();
        int rx;
        int ry;
        rx = $urandom_range(0, 255);
        ry = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 1 && visible_w() > 0) rx = $urandom_range(0, visible_w() - 1);
        if ($urandom_range(0, 1) == 1 && visible_h() > 0) ry = $urandom_range(0, visible_h() - 1);
        return read_cmd(rx, ry);
    endfunction

    task automatic issue(t_raster_cmd c);
        cmd_backlog.push_back(c);
        issued++;
    endtask

    task automatic drain();
        while (results_seen != issued) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_X_ORIGIN:      org_x = int'($signed(val));
            REG_Y_ORIGIN:      org_y = int'($signed(val));
            REG_SCREEN_WIDTH:  scr_w = int'(val[SCR_W-1:0]);
            REG_SCREEN_HEIGHT: scr_h = int'(val[SCR_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic run_phase(int ox, int oy, int w, int h, int n_items);
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        wd = CFG_DATA_W'($urandom);
        hd = CFG_DATA_W'($urandom);
        wd[SCR_W-1:0] = w[SCR_W-1:0];
        hd[SCR_W-1:0] = h[SCR_W-1:0];
        write_reg(REG_X_ORIGIN, ox[CFG_DATA_W-1:0]);
        write_reg(REG_Y_ORIGIN, oy[CFG_DATA_W-1:0]);
        write_reg(REG_SCREEN_WIDTH, wd);
        write_reg(REG_SCREEN_HEIGHT, hd);
        n_settings++;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 45) issue(random_read());
            else issue(random_line());
        end
        drain();
    endtask

    task automatic check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
            errors++;
        end
    endtask

    // Request source.
    always @(posedge i_clk) begin
        t_raster_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(raster_predict(held_cmd));
                if (held_cmd.op == OP_DRAW) begin
                    n_draws++;
                end else begin
                    n_reads++;
                    if (awaited_results[$].outside) n_outside++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    nxt = cmd_backlog.pop_front();
                    held_cmd = nxt;
                    s_axis_tdata  <= {nxt.ry, nxt.rx, nxt.ty, nxt.tx, nxt.fy, nxt.fx};
                    s_axis_tuser  <= nxt.op;
                    s_axis_tvalid <= 1'b1;
                    if (src_calm > 0) begin
                        src_calm--;
                        src_gap = 0;
                    end else begin
                        if ($urandom_range(0, 49) == 0) src_calm = $urandom_range(20, 60);
                        src_gap = pick_gap();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response sink and checker.
    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    if (errors < MAX_REPORTS) begin
                        $display("%0t: unexpected response, actual color %h flags %b",
                                 $time, m_axis_tdata, m_axis_tuser);
                    end
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("pixel_color", want.color, m_axis_tdata);
                    check_field("line_done", COLOR_W'(want.done), COLOR_W'(m_axis_tuser[0]));
                    check_field("read_outside", COLOR_W'(want.outside),
                                COLOR_W'(m_axis_tuser[1]));
                end
                if (results_seen == 150 || results_seen == 450) begin
                    sink_wait = LONG_HOLD;
                end else if (sink_calm > 0) begin
                    sink_calm--;
                    sink_wait = 0;
                end else begin
                    if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(20, 60);
                    sink_wait = pick_gap();
                end
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_axis_tready <= (sink_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d of %0d responses seen",
                     $time, idle_cycles, results_seen, issued);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (pix_white[i]) pix_white[i] = 1'b1;
        org_x = 0;
        org_y = 0;
        scr_w = PIX_W;
        scr_h = PIX_H;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, a degenerate line, vertical lines with clipping,
        // sloped lines in three of the four directions and one full-range line.
        n_settings = 1;
        issue(read_cmd(0, 0));
        issue(read_cmd(255, 255));
        issue(line_cmd(5, 5, 5, 5));
        issue(read_cmd(5, 5));
        issue(line_cmd(10, 20, 10, 30));
        issue(read_cmd(10, 20));
        issue(read_cmd(10, 29));
        issue(read_cmd(10, 30));
        issue(line_cmd(12, -5, 12, 300));
        issue(read_cmd(12, 255));
        issue(line_cmd(-1, 0, -1, 50));
        issue(line_cmd(256, 0, 256, 50));
        issue(line_cmd(0, 0, 20, 7));
        issue(line_cmd(20, 0, 0, 40));
        issue(line_cmd(40, 40, 30, 35));
        issue(line_cmd(-10, -10, 300, 300));
        issue(line_cmd(50, 60, 90, 60));
        issue(read_cmd(20, 7));
        issue(line_cmd(-32768, -32768, 32767, 32767));
        issue(read_cmd(128, 128));
        issue(read_cmd(0, 1));
        drain();

        run_phase(32767, 32767, 256, 256, 70);
        run_phase(-32768, -32768, 511, 300, 20);
        run_phase(-32500, -32000, 1, 1, 40);
        run_phase(0, 0, 0, 200, 40);
        run_phase(5, -3, 100, 0, 40);
        run_phase(0, 0, 160, 120, 80);
        for (int p = 0; p < 4; p++) begin
            run_phase(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(60, 256),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(60, 256),
                      90);
        end

        errors += awaited_results.size();
        $display("Covered %0d line draws and %0d pixel reads (%0d off screen) over %0d settings.",
                 n_draws, n_reads, n_outside, n_settings);
        $display("Mismatches counted: %0d.", errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
